// ===== sv/ptp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptp_pkg
// shared types and constants for the priority table with promote and pop
// ----------------------------------------------------------------------------
package ptp_pkg;

  // default sizes
  localparam int unsigned CAPACITY_DEF       = 16;
  localparam int unsigned PAYLOAD_WIDTH_DEF  = 32;
  localparam int unsigned PRIORITY_WIDTH_DEF = 16;

  // fixed port widths
  localparam int unsigned ID_W       = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PRI_OUT_W  = 16;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned STATUS_W   = 2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 3'd0,
    OP_IS_VALID = 3'd1,
    OP_GET      = 3'd2,
    OP_PROMOTE  = 3'd3,
    OP_GET_MAX  = 3'd4,
    OP_POP_MAX  = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

endpackage

// ===== sv/priority_table_promote_pop.sv =====
// ----------------------------------------------------------------------------
// priority_table_promote_pop
// table of entries keyed by id with add, lookup, promote and max/pop-max
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              fields
//  --------  ---------  ---------------------  ----------------------------------
//  command   in         start & !busy          op_i, entry_id_i, payload_in_i
//  result    out        done_o (1-cycle pulse) status_o, id_out_o, payload_out_o,
//                                              priority_out_o, is_live_o
//
//  done_o is shown after the accepting edge once S_SCAN has issued one slot read
//  per cycle for every slot, S_DRAIN has evaluated the last slot and S_FINISH
//  has written back and registered the result; a new command is taken only once
//  the previous result is out; the scan is bound by the single read port of the
//  slot memory, scanned by one shared id/priority comparator
//  after reset a clearing pass in S_CLEAR marks all slots free; busy is
//  high during it
//  busy is high from acceptance until the result cycle; the next transaction
//  may be accepted in the cycle done_o is shown
//  the receiver cannot stall: each result is shown for exactly one cycle
//
module priority_table_promote_pop #(
  parameter int unsigned CAPACITY       = ptp_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_WIDTH  = ptp_pkg::PAYLOAD_WIDTH_DEF,
  parameter int unsigned PRIORITY_WIDTH = ptp_pkg::PRIORITY_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command side
  input  logic                             start,
  output logic                             busy,
  input  logic [ptp_pkg::OP_W-1:0]         op_i,
  input  logic [ptp_pkg::ID_W-1:0]         entry_id_i,
  input  logic [ptp_pkg::DATA_W-1:0]       payload_in_i,
  // result side
  output logic                             done_o,
  output logic [ptp_pkg::STATUS_W-1:0]     status_o,
  output logic [ptp_pkg::ID_W-1:0]         id_out_o,
  output logic [ptp_pkg::DATA_W-1:0]       payload_out_o,
  output logic [ptp_pkg::PRI_OUT_W-1:0]    priority_out_o,
  output logic                             is_live_o
);

  // stored payload never exceeds the port width
  localparam int unsigned SPW   = (PAYLOAD_WIDTH < ptp_pkg::DATA_W) ?
                                  PAYLOAD_WIDTH : ptp_pkg::DATA_W;
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // one memory word per slot
  typedef struct packed {
    logic                      used;
    logic [ptp_pkg::ID_W-1:0]  id;
    logic [PRIORITY_WIDTH-1:0] pri;
    logic [SPW-1:0]            pay;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e                        state_q, state_d;
  logic [IDX_W-1:0]              idx_q, idx_d;         // read address being issued
  ptp_pkg::op_e                  op_q, op_d;
  logic [ptp_pkg::ID_W-1:0]      qid_q, qid_d;
  logic [SPW-1:0]                pin_q, pin_d;
  logic                          found_q, found_d;     // a slot has been picked
  logic [IDX_W-1:0]              slot_q, slot_d;       // picked slot
  slot_t                         best_q, best_d;       // contents of picked slot
  logic                          rd_vld_q, rd_vld_d;   // read data is a scanned slot
  logic [IDX_W-1:0]              rd_idx_q, rd_idx_d;   // slot of the read data
  logic [ptp_pkg::ID_W-1:0]      ctr_q, ctr_d;         // next id to hand out
  logic                          done_q, done_d;
  ptp_pkg::status_e              status_q, status_d;
  logic [ptp_pkg::ID_W-1:0]      id_out_q, id_out_d;
  logic [ptp_pkg::DATA_W-1:0]    pay_out_q, pay_out_d;
  logic [ptp_pkg::PRI_OUT_W-1:0] pri_out_q, pri_out_d;
  logic                          live_q, live_d;

  // slot memory
  slot_t                         mem_q [CAPACITY];
  slot_t                         rd_word_q;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_wa;
  slot_t                         mem_wd;

  // shared compare unit
  logic                          take;
  logic                          id_hit;
  logic                          pri_gt;
  logic                          pri_eq;
  logic                          id_gt;

  // widening helpers for the output fields
  logic [PRIORITY_WIDTH+ptp_pkg::PRI_OUT_W-1:0] pri_ext;
  logic [SPW+ptp_pkg::DATA_W-1:0]               pay_ext;
  logic [PRIORITY_WIDTH-1:0]                    pri_inc;

  // --------------------------------------------------------------------------
  // memory: one write and one registered read per cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_word_q <= mem_q[idx_q];
  end

  // --------------------------------------------------------------------------
  // compare unit: decides whether the slot just read replaces the pick
  // --------------------------------------------------------------------------
  assign id_hit = (rd_word_q.id == qid_q);
  assign pri_gt = (rd_word_q.pri > best_q.pri);
  assign pri_eq = (rd_word_q.pri == best_q.pri);
  assign id_gt  = (rd_word_q.id > best_q.id);

  always_comb begin
    take = 1'b0;
    case (op_q)
      // lowest free slot
      ptp_pkg::OP_ADD: take = !found_q && !rd_word_q.used;
      // lowest live slot with a matching id
      ptp_pkg::OP_IS_VALID,
      ptp_pkg::OP_GET,
      ptp_pkg::OP_PROMOTE: take = !found_q && rd_word_q.used && id_hit;
      // highest priority, then larger id; a full tie keeps the lower slot
      ptp_pkg::OP_GET_MAX,
      ptp_pkg::OP_POP_MAX: take = rd_word_q.used &&
                                  (!found_q || pri_gt || (pri_eq && id_gt));
      default: take = 1'b0;
    endcase
  end

  // saturating increment for promote
  assign pri_inc = (&best_q.pri) ? best_q.pri : best_q.pri + PRIORITY_WIDTH'(1);
  assign pri_ext = {{ptp_pkg::PRI_OUT_W{1'b0}}, best_q.pri};
  assign pay_ext = {{ptp_pkg::DATA_W{1'b0}}, best_q.pay};

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    op_d      = op_q;
    qid_d     = qid_q;
    pin_d     = pin_q;
    found_d   = found_q;
    slot_d    = slot_q;
    best_d    = best_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = idx_q;
    ctr_d     = ctr_q;
    done_d    = 1'b0;
    status_d  = status_q;
    id_out_d  = id_out_q;
    pay_out_d = pay_out_q;
    pri_out_d = pri_out_q;
    live_d    = live_q;
    mem_we    = 1'b0;
    mem_wa    = slot_q;
    mem_wd    = best_q;

    // fold the slot read last cycle into the pick
    if (rd_vld_q && take) begin
      found_d = 1'b1;
      slot_d  = rd_idx_q;
      best_d  = rd_word_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = ptp_pkg::op_e'(op_i);
          qid_d   = entry_id_i;
          pin_d   = payload_in_i[SPW-1:0];
          found_d = 1'b0;
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_CLEAR: begin
        // mark every slot free after reset
        mem_we = 1'b1;
        mem_wa = idx_q;
        mem_wd = '0;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_SCAN: begin
        rd_vld_d = 1'b1;
        rd_idx_d = idx_q;
        if (idx_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        // last slot is evaluated this cycle
        state_d = S_FINISH;
      end
      S_FINISH: begin
        done_d    = 1'b1;
        status_d  = ptp_pkg::ST_OK;
        id_out_d  = '0;
        pay_out_d = '0;
        pri_out_d = '0;
        live_d    = 1'b0;
        idx_d     = '0;
        state_d   = S_IDLE;
        case (op_q)
          ptp_pkg::OP_ADD: begin
            if (!found_q) begin
              status_d = ptp_pkg::ST_FULL;
            end else begin
              mem_we   = 1'b1;
              mem_wd   = '{used: 1'b1, id: ctr_q, pri: '0, pay: pin_q};
              id_out_d = ctr_q;
              ctr_d    = ctr_q + ptp_pkg::ID_W'(1);
            end
          end
          ptp_pkg::OP_IS_VALID: begin
            live_d = found_q;
          end
          ptp_pkg::OP_GET: begin
            if (!found_q) begin
              status_d = ptp_pkg::ST_UNKNOWN;
            end else begin
              id_out_d  = qid_q;
              pay_out_d = pay_ext[ptp_pkg::DATA_W-1:0];
              pri_out_d = pri_ext[ptp_pkg::PRI_OUT_W-1:0];
            end
          end
          ptp_pkg::OP_PROMOTE: begin
            if (!found_q) begin
              status_d = ptp_pkg::ST_UNKNOWN;
            end else begin
              mem_we     = 1'b1;
              mem_wd.pri = pri_inc;
              id_out_d   = qid_q;
              pri_out_d  = ptp_pkg::PRI_OUT_W'({{ptp_pkg::PRI_OUT_W{1'b0}}, pri_inc});
            end
          end
          ptp_pkg::OP_GET_MAX,
          ptp_pkg::OP_POP_MAX: begin
            if (!found_q) begin
              status_d = ptp_pkg::ST_EMPTY;
            end else begin
              id_out_d  = best_q.id;
              pay_out_d = pay_ext[ptp_pkg::DATA_W-1:0];
              pri_out_d = pri_ext[ptp_pkg::PRI_OUT_W-1:0];
              if (op_q == ptp_pkg::OP_POP_MAX) begin
                // free the slot
                mem_we      = 1'b1;
                mem_wd.used = 1'b0;
              end
            end
          end
          default: begin
            // unused codes: ok status, all fields zero
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      op_q      <= ptp_pkg::OP_ADD;
      qid_q     <= '0;
      pin_q     <= '0;
      found_q   <= 1'b0;
      slot_q    <= '0;
      best_q    <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      ctr_q     <= '0;
      done_q    <= 1'b0;
      status_q  <= ptp_pkg::ST_OK;
      id_out_q  <= '0;
      pay_out_q <= '0;
      pri_out_q <= '0;
      live_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      op_q      <= op_d;
      qid_q     <= qid_d;
      pin_q     <= pin_d;
      found_q   <= found_d;
      slot_q    <= slot_d;
      best_q    <= best_d;
      rd_vld_q  <= rd_vld_d;
      rd_idx_q  <= rd_idx_d;
      ctr_q     <= ctr_d;
      done_q    <= done_d;
      status_q  <= status_d;
      id_out_q  <= id_out_d;
      pay_out_q <= pay_out_d;
      pri_out_q <= pri_out_d;
      live_q    <= live_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign id_out_o       = id_out_q;
  assign payload_out_o  = pay_out_q;
  assign priority_out_o = pri_out_q;
  assign is_live_o      = live_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted transaction did not raise busy");

  a_finish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |=> (done_o && !busy))
    else $error("finish step did not deliver a result");

  a_ctr_only_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctr_q != $past(ctr_q)) |->
      (done_o && $past(op_q == ptp_pkg::OP_ADD) && status_o == ptp_pkg::ST_OK))
    else $error("id counter moved outside a successful add");

  a_live_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_live_o |-> (status_o == ptp_pkg::ST_OK))
    else $error("live flag with an error status");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks priority_table_promote_pop against a cycle-free model of the table:
// a directed table of corner cases, a long random mix of fill and drain
// traffic with random idle cycles on the command side, and a short promote run
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CAPACITY       = ptp_pkg::CAPACITY_DEF;
  localparam int unsigned PAYLOAD_WIDTH  = ptp_pkg::PAYLOAD_WIDTH_DEF;
  localparam int unsigned PRIORITY_WIDTH = ptp_pkg::PRIORITY_WIDTH_DEF;

  // op codes the block decodes as no-ops
  localparam logic [ptp_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [ptp_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam logic [PRIORITY_WIDTH-1:0] PRI_MAX = {PRIORITY_WIDTH{1'b1}};
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned PROMOTE_RUN  = 8;
  localparam int unsigned SHOW_LIMIT   = 10;
  // about 550 transactions in all
  localparam int unsigned CYCLE_LIMIT  = 100_000;

  // one result transaction, as seen on the result ports
  typedef struct packed {
    ptp_pkg::status_e              status;
    logic [ptp_pkg::ID_W-1:0]      id;
    logic [ptp_pkg::DATA_W-1:0]    payload;
    logic [ptp_pkg::PRI_OUT_W-1:0] prio;
    logic                          live;
  } table_result_t;

  // one row of the directed stimulus table
  typedef struct {
    logic [ptp_pkg::OP_W-1:0]   op;
    logic [ptp_pkg::ID_W-1:0]   qid;
    logic [ptp_pkg::DATA_W-1:0] pin;
    bit                         typed;
    table_result_t              want;
  } directed_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic [ptp_pkg::OP_W-1:0]      op_i;
  logic [ptp_pkg::ID_W-1:0]      entry_id_i;
  logic [ptp_pkg::DATA_W-1:0]    payload_in_i;
  logic                          done_o;
  logic [ptp_pkg::STATUS_W-1:0]  status_o;
  logic [ptp_pkg::ID_W-1:0]      id_out_o;
  logic [ptp_pkg::DATA_W-1:0]    payload_out_o;
  logic [ptp_pkg::PRI_OUT_W-1:0] priority_out_o;
  logic                          is_live_o;

  priority_table_promote_pop #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .PRIORITY_WIDTH(PRIORITY_WIDTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .entry_id_i    (entry_id_i),
    .payload_in_i  (payload_in_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .id_out_o      (id_out_o),
    .payload_out_o (payload_out_o),
    .priority_out_o(priority_out_o),
    .is_live_o     (is_live_o)
  );

  // clock, 12 units per period
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // table model: own copy of the slots and the id counter
  // ---------------------------------------------------------------------------
  logic                      slot_used_q [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0]  slot_pay_q  [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] slot_pri_q  [CAPACITY];
  logic [ptp_pkg::ID_W-1:0]  slot_id_q   [CAPACITY];
  logic [ptp_pkg::ID_W-1:0]  next_id_q;

  // results still owed by the block, oldest first
  table_result_t pending_results [$];
  directed_row_t directed_rows [$];

  int unsigned fault_count;
  int unsigned cycle_count;
  bit          gaps_on;

  // applies one command to the model table and returns its result
  function automatic table_result_t apply_table_op(
    input logic [ptp_pkg::OP_W-1:0]   op,
    input logic [ptp_pkg::ID_W-1:0]   qid,
    input logic [ptp_pkg::DATA_W-1:0] pin);
    table_result_t res;
    int hit_slot;
    int max_slot;
    int free_slot;
    res       = '0;
    res.status = ptp_pkg::ST_OK;
    hit_slot  = -1;
    max_slot  = -1;
    free_slot = -1;
    // lowest matching slot wins, lowest slot wins a full tie on the max
    for (int i = 0; i < CAPACITY; i++) begin
      if (!slot_used_q[i]) begin
        if (free_slot < 0) free_slot = i;
      end else begin
        if (hit_slot < 0 && slot_id_q[i] == qid) hit_slot = i;
        if (max_slot < 0 || slot_pri_q[i] > slot_pri_q[max_slot] ||
            (slot_pri_q[i] == slot_pri_q[max_slot] && slot_id_q[i] > slot_id_q[max_slot]))
          max_slot = i;
      end
    end
    case (op)
      ptp_pkg::OP_ADD: begin
        if (free_slot < 0) begin
          res.status = ptp_pkg::ST_FULL;
        end else begin
          slot_used_q[free_slot] = 1'b1;
          slot_pay_q[free_slot]  = pin[PAYLOAD_WIDTH-1:0];
          slot_pri_q[free_slot]  = '0;
          slot_id_q[free_slot]   = next_id_q;
          res.id                 = next_id_q;
          next_id_q              = next_id_q + 1'b1;
        end
      end
      ptp_pkg::OP_IS_VALID: res.live = (hit_slot >= 0);
      ptp_pkg::OP_GET, ptp_pkg::OP_PROMOTE: begin
        if (hit_slot < 0) begin
          res.status = ptp_pkg::ST_UNKNOWN;
        end else begin
          if (op == ptp_pkg::OP_PROMOTE) begin
            if (slot_pri_q[hit_slot] != PRI_MAX) slot_pri_q[hit_slot] += 1'b1;
          end else begin
            res.payload = ptp_pkg::DATA_W'(slot_pay_q[hit_slot]);
          end
          res.id   = qid;
          res.prio = ptp_pkg::PRI_OUT_W'(slot_pri_q[hit_slot]);
        end
      end
      ptp_pkg::OP_GET_MAX, ptp_pkg::OP_POP_MAX: begin
        if (max_slot < 0) begin
          res.status = ptp_pkg::ST_EMPTY;
        end else begin
          res.id      = slot_id_q[max_slot];
          res.payload = ptp_pkg::DATA_W'(slot_pay_q[max_slot]);
          res.prio    = ptp_pkg::PRI_OUT_W'(slot_pri_q[max_slot]);
          if (op == ptp_pkg::OP_POP_MAX) slot_used_q[max_slot] = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // mostly live ids, some just freed or not yet handed out, some anything
  function automatic logic [ptp_pkg::ID_W-1:0] pick_lookup_id();
    int live_slots [$];
    int roll;
    for (int i = 0; i < CAPACITY; i++)
      if (slot_used_q[i]) live_slots.push_back(i);
    roll = $urandom_range(99);
    if (roll < 70 && live_slots.size() > 0)
      return slot_id_q[live_slots[$urandom_range(live_slots.size() - 1)]];
    else if (roll < 85)
      return next_id_q - $urandom_range(20);
    return $urandom;
  endfunction

  task automatic add_directed_row(input logic [ptp_pkg::OP_W-1:0] op,
                                  input logic [ptp_pkg::ID_W-1:0] qid,
                                  input logic [ptp_pkg::DATA_W-1:0] pin, input bit typed,
                                  input ptp_pkg::status_e st,
                                  input logic [ptp_pkg::ID_W-1:0] rid,
                                  input logic [ptp_pkg::DATA_W-1:0] rpay,
                                  input logic [ptp_pkg::PRI_OUT_W-1:0] rpri,
                                  input logic rlive);
    directed_row_t row;
    row.op           = op;
    row.qid          = qid;
    row.pin          = pin;
    row.typed        = typed;
    row.want.status  = st;
    row.want.id      = rid;
    row.want.payload = rpay;
    row.want.prio    = rpri;
    row.want.live    = rlive;
    directed_rows.push_back(row);
  endtask

  // drives one command transaction; called and returns at a falling edge
  task automatic issue_cmd(input logic [ptp_pkg::OP_W-1:0] op,
                           input logic [ptp_pkg::ID_W-1:0] qid,
                           input logic [ptp_pkg::DATA_W-1:0] pin, input bit typed,
                           input table_result_t typed_want);
    table_result_t model_out;
    bit            drive;
    bit            taken;
    op_i         <= op;
    entry_id_i   <= qid;
    payload_in_i <= pin;
    taken        = 1'b0;
    while (!taken) begin
      // with gaps on, start idles with a chance of about 37 in a hundred
      drive = !(gaps_on && $urandom_range(99) < 37);
      start <= drive;
      @(posedge clk_i);
      // accepted at a rising edge with start high and busy low
      taken = drive && (busy === 1'b0);
      if (!taken) @(negedge clk_i);
    end
    model_out = apply_table_op(op, qid, pin);
    pending_results.push_back(typed ? typed_want : model_out);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result checker: every done_o pulse is one result transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    table_result_t got;
    table_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      got.status  = ptp_pkg::status_e'(status_o);
      got.id      = id_out_o;
      got.payload = payload_out_o;
      got.prio    = priority_out_o;
      got.live    = is_live_o;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOW_LIMIT)
          $display("[%0d] unexpected result: status %0d id %h payload %h prio %h live %b",
                   cycle_count, got.status, got.id, got.payload, got.prio, got.live);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= SHOW_LIMIT)
            $display({"[%0d] mismatch: expected status %0d id %h payload %h prio %h live %b,",
                      " got status %0d id %h payload %h prio %h live %b"},
                     cycle_count, want.status, want.id, want.payload, want.prio, want.live,
                     got.status, got.id, got.payload, got.prio, got.live);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [ptp_pkg::OP_W-1:0] op;
    logic [ptp_pkg::ID_W-1:0] qid;
    int                       roll;
    bit                       filling;
    logic [ptp_pkg::ID_W-1:0] hot_id;

    rst_ni       = 1'b0;
    start        = 1'b0;
    op_i         = ptp_pkg::OP_ADD;
    entry_id_i   = '0;
    payload_in_i = '0;
    fault_count  = 0;
    cycle_count  = 0;
    gaps_on      = 1'b1;
    next_id_q    = '0;
    for (int i = 0; i < CAPACITY; i++) slot_used_q[i] = 1'b0;

    // directed corner cases; typed rows carry their own expectation
    // empty table, unknown ids, reserved ops
    add_directed_row(ptp_pkg::OP_GET_MAX,  '0, '0, 1, ptp_pkg::ST_EMPTY, '0, '0, '0, 1'b0);
    add_directed_row(ptp_pkg::OP_POP_MAX,  '0, '0, 1, ptp_pkg::ST_EMPTY, '0, '0, '0, 1'b0);
    add_directed_row(ptp_pkg::OP_GET,      '0, '0, 1, ptp_pkg::ST_UNKNOWN, '0, '0, '0, 1'b0);
    add_directed_row(ptp_pkg::OP_PROMOTE,  '1, '1, 1, ptp_pkg::ST_UNKNOWN, '0, '0, '0, 1'b0);
    add_directed_row(ptp_pkg::OP_IS_VALID, '0, '0, 1, ptp_pkg::ST_OK, '0, '0, '0, 1'b0);
    add_directed_row(OP_RSVD_6,            '1, '1, 1, ptp_pkg::ST_OK, '0, '0, '0, 1'b0);
    add_directed_row(OP_RSVD_7,            '0, '1, 1, ptp_pkg::ST_OK, '0, '0, '0, 1'b0);
    // first ids, payload extremes
    add_directed_row(ptp_pkg::OP_ADD,      '1, '0, 1, ptp_pkg::ST_OK, 32'd0, '0, '0, 1'b0);
    add_directed_row(ptp_pkg::OP_ADD,      '0, '1, 1, ptp_pkg::ST_OK, 32'd1, '0, '0, 1'b0);
    add_directed_row(ptp_pkg::OP_IS_VALID, '0, '0, 1, ptp_pkg::ST_OK, '0, '0, '0, 1'b1);
    add_directed_row(ptp_pkg::OP_GET,      32'd1, '0, 1, ptp_pkg::ST_OK, 32'd1, '1, 16'd0,
                     1'b0);
    add_directed_row(ptp_pkg::OP_PROMOTE,  32'd0, '0, 1, ptp_pkg::ST_OK, 32'd0, '0, 16'd1,
                     1'b0);
    add_directed_row(ptp_pkg::OP_GET_MAX,  '0, '0, 1, ptp_pkg::ST_OK, 32'd0, '0, 16'd1, 1'b0);
    // tie on priority goes to the larger id
    add_directed_row(ptp_pkg::OP_PROMOTE,  32'd1, '0, 1, ptp_pkg::ST_OK, 32'd1, '0, 16'd1,
                     1'b0);
    add_directed_row(ptp_pkg::OP_GET_MAX,  '0, '0, 1, ptp_pkg::ST_OK, 32'd1, '1, 16'd1, 1'b0);
    add_directed_row(ptp_pkg::OP_POP_MAX,  '0, '0, 1, ptp_pkg::ST_OK, 32'd1, '1, 16'd1, 1'b0);
    add_directed_row(ptp_pkg::OP_GET,      32'd1, '0, 1, ptp_pkg::ST_UNKNOWN, '0, '0, '0,
                     1'b0);
    add_directed_row(ptp_pkg::OP_IS_VALID, 32'd1, '0, 1, ptp_pkg::ST_OK, '0, '0, '0, 1'b0);
    // freed slot is reused under a fresh id
    add_directed_row(ptp_pkg::OP_ADD,      '0, 32'h5a5a_a5a5, 0, ptp_pkg::ST_OK, '0, '0, '0,
                     1'b0);
    add_directed_row(ptp_pkg::OP_GET_MAX,  '0, '0, 0, ptp_pkg::ST_OK, '0, '0, '0, 1'b0);
    add_directed_row(ptp_pkg::OP_POP_MAX,  '0, '0, 0, ptp_pkg::ST_OK, '0, '0, '0, 1'b0);
    add_directed_row(ptp_pkg::OP_POP_MAX,  '0, '0, 0, ptp_pkg::ST_OK, '0, '0, '0, 1'b0);
    add_directed_row(ptp_pkg::OP_POP_MAX,  '0, '0, 1, ptp_pkg::ST_EMPTY, '0, '0, '0, 1'b0);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // the block clears its slots first; busy holds the first transaction off
    foreach (directed_rows[r])
      issue_cmd(directed_rows[r].op, directed_rows[r].qid, directed_rows[r].pin,
                directed_rows[r].typed, directed_rows[r].want);

    // random traffic in blocks that alternately lean toward filling and toward
    // draining the table; a stretch in the middle runs with no idle cycles
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      filling = ((n / 50) % 2) == 0;
      gaps_on = !(n >= 250 && n < 350);
      roll    = $urandom_range(99);
      if (roll < (filling ? 45 : 10))      op = ptp_pkg::OP_ADD;
      else if (roll < (filling ? 55 : 20)) op = ptp_pkg::OP_IS_VALID;
      else if (roll < (filling ? 65 : 30)) op = ptp_pkg::OP_GET;
      else if (roll < (filling ? 83 : 47)) op = ptp_pkg::OP_PROMOTE;
      else if (roll < (filling ? 89 : 57)) op = ptp_pkg::OP_GET_MAX;
      else if (roll < (filling ? 96 : 95)) op = ptp_pkg::OP_POP_MAX;
      else                                 op = $urandom_range(1) ? OP_RSVD_6 : OP_RSVD_7;
      qid = (op == ptp_pkg::OP_ADD || op == ptp_pkg::OP_GET_MAX ||
             op == ptp_pkg::OP_POP_MAX) ? $urandom : pick_lookup_id();
      issue_cmd(op, qid, $urandom, 0, '0);
    end

    // empty the table, then promote one entry a few times and pop it
    gaps_on = 1'b0;
    for (int k = 0; k < CAPACITY; k++)
      issue_cmd(ptp_pkg::OP_POP_MAX, $urandom, $urandom, 0, '0);
    hot_id = next_id_q;
    issue_cmd(ptp_pkg::OP_ADD, $urandom, $urandom, 0, '0);
    for (int k = 0; k < PROMOTE_RUN; k++)
      issue_cmd(ptp_pkg::OP_PROMOTE, hot_id, $urandom, 0, '0);
    issue_cmd(ptp_pkg::OP_GET, hot_id, $urandom, 0, '0);
    issue_cmd(ptp_pkg::OP_POP_MAX, $urandom, $urandom, 0, '0);
    start <= 1'b0;

    // wait for the last result, then a little longer for stray strobes
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);

    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ptp_pkg.sv
sv/priority_table_promote_pop.sv
bench/testbench.sv
